// ----- rtl/firfc_pkg.sv -----
// Shared types and constants for the full-convolution FIR block.
package firfc_pkg;

  // Fixed field widths.
  localparam int COEF_W     = 16;
  localparam int IN_SMP_W   = 16;
  localparam int IDX_FLD_W  = 5;
  localparam int OUT_W      = 40;
  localparam int TAPS_CFG_W = 6;

  // Reset value of the active tap count register.
  localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 6'd32;

  // Command codes.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // One input word.
  typedef struct packed {
    logic                        command;
    logic signed [IN_SMP_W-1:0]  sample_value;
    logic                        block_end;
    logic [IDX_FLD_W-1:0]        coef_index;
    logic signed [COEF_W-1:0]    coef_value;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic signed [OUT_W-1:0] filtered_value;
    logic                    last_of_block;
  } out_word_t;

  // Controls shared by every cell of the ring.
  typedef struct packed {
    logic shift;   // move samples one cell down, new sample into cell 0
    logic rotate;  // turn samples and coefficients one cell toward cell 0
    logic clear;   // zero all samples
  } cell_ctl_t;

  // Controls of the multiply-accumulate unit at the ring head.
  typedef struct packed {
    logic clear;   // start a new sum
    logic issue;   // the head product counts toward the sum
  } mac_ctl_t;

endpackage

// ----- rtl/firfc_cell.sv -----
// One tap cell: holds one delay-line sample and one coefficient.
module firfc_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  firfc_pkg::cell_ctl_t                 ctl,
  input  logic                                 coef_wr_en,
  input  logic signed [firfc_pkg::COEF_W-1:0]  coef_wr_data,
  input  logic signed [SAMPLE_BITS-1:0]        x_prev,
  input  logic signed [SAMPLE_BITS-1:0]        x_next,
  input  logic signed [firfc_pkg::COEF_W-1:0]  c_next,
  output logic signed [SAMPLE_BITS-1:0]        x_q,
  output logic signed [firfc_pkg::COEF_W-1:0]  c_q
);
  import firfc_pkg::*;

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [COEF_W-1:0]      c_r;

  // Sample register: cleared at reset and at the end of a block.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      x_r <= '0;
    end else if (ctl.shift) begin
      x_r <= x_prev;
    end else if (ctl.rotate) begin
      x_r <= x_next;
    end
  end

  // Coefficient register: written by a load, turned with the ring.
  always_ff @(posedge clk) begin
    if (coef_wr_en) begin
      c_r <= coef_wr_data;
    end else if (ctl.rotate) begin
      c_r <= c_next;
    end
  end

  assign x_q = x_r;
  assign c_q = c_r;

endmodule

// ----- rtl/firfc_mac.sv -----
// Multiply-accumulate unit fed by the cell at the head of the ring.
module firfc_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  firfc_pkg::mac_ctl_t                  ctl,
  input  logic signed [SAMPLE_BITS-1:0]        x_in,
  input  logic signed [firfc_pkg::COEF_W-1:0]  c_in,
  output logic signed [firfc_pkg::OUT_W-1:0]   acc
);
  import firfc_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + COEF_W;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic signed [OUT_W-1:0]  acc_r;
  logic signed [OUT_W-1:0]  acc_nxt;

  // Registered product of the head cell.
  always_ff @(posedge clk) begin
    prod_r <= x_in * c_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.issue;
    end
  end

  // Running sum, wrapping at the output width.
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + OUT_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ----- rtl/fir_full_convolution.sv -----
// Top level of the full-convolution FIR block: tap ring, MAC and sequencer.
//
//   Channel   Direction  Handshake                 Word
//   in_       input      in_valid / in_stall       in_word  (command, sample, coefficient)
//   out_      output     out_valid / out_stall     out_word (filtered_value, last_of_block)
//   cfg_      input      cfg_wr_en                 cfg_wr_data (taps_in_use)
//
// A coefficient load leaves the block ready: in_stall stays low.
// A sample shifts into cell 0 on its accepting edge, then holds in_stall high while
// the ring turns a full circle through the single MAC, the last product drains
// into the sum and the sum is handed to the output register. A block end adds
// tail words, one fewer than taps_in_use limited to 1..TAP_COUNT. Reset zeros the delay
// line and sets taps_in_use to 32; while out_stall holds a word, the next sum waits.
module fir_full_convolution #(
  parameter int TAP_COUNT   = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  firfc_pkg::in_word_t                   in_word,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output firfc_pkg::out_word_t                  out_word,
  input  logic                                  cfg_wr_en,
  input  logic [firfc_pkg::TAPS_CFG_W-1:0]      cfg_wr_data
);
  import firfc_pkg::*;

  localparam int CNT_W = $clog2(TAP_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        taps_r, taps_nxt;
  logic [CNT_W-1:0]        tail_r, tail_nxt;
  logic                    blk_r, blk_nxt;
  logic [TAPS_CFG_W-1:0]   taps_cfg_r;
  logic [CNT_W-1:0]        taps_eff;
  logic                    out_valid_r;
  out_word_t               out_word_r;

  logic                    in_acc;
  logic                    is_load;
  logic                    out_free;
  logic                    done_go;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic signed [SAMPLE_BITS-1:0] head_in;
  cell_ctl_t               cell_ctl;
  mac_ctl_t                mac_ctl;
  logic signed [OUT_W-1:0] acc;

  logic signed [SAMPLE_BITS-1:0] x_q [TAP_COUNT];
  logic signed [COEF_W-1:0]      c_q [TAP_COUNT];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_cfg_r <= TAPS_RESET;
    end else if (cfg_wr_en) begin
      taps_cfg_r <= cfg_wr_data;
    end
  end

  // Active tap count, limited to 1..TAP_COUNT.
  always_comb begin
    if (taps_cfg_r == '0) begin
      taps_eff = CNT_W'(1);
    end else if (int'(taps_cfg_r) > TAP_COUNT) begin
      taps_eff = CNT_W'(TAP_COUNT);
    end else begin
      taps_eff = CNT_W'(taps_cfg_r);
    end
  end

  // Sample taken at the delay-line width.
  generate
    if (SAMPLE_BITS <= IN_SMP_W) begin : g_smp_trunc
      assign sample_in = in_word.sample_value[SAMPLE_BITS-1:0];
    end else begin : g_smp_ext
      assign sample_in = SAMPLE_BITS'(in_word.sample_value);
    end
  endgenerate

  // Handshake decode.
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_load  = (in_word.command == CMD_LOAD);
  assign out_free = !out_valid_r || !out_stall;
  assign done_go  = (state_r == S_DONE) && out_free;

  // Ring and MAC controls.
  always_comb begin
    cell_ctl.shift  = (in_acc && !is_load) || (done_go && (tail_r != '0));
    cell_ctl.rotate = (state_r == S_RUN) && (cnt_r < CNT_W'(TAP_COUNT));
    cell_ctl.clear  = done_go && (tail_r == '0) && blk_r;
    mac_ctl.clear   = cell_ctl.shift;
    mac_ctl.issue   = cell_ctl.rotate && (cnt_r < taps_r);
  end

  // Tail words shift in zeros.
  assign head_in = (state_r == S_DONE) ? '0 : sample_in;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    taps_nxt  = taps_r;
    tail_nxt  = tail_r;
    blk_nxt   = blk_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !is_load) begin
          state_nxt = S_RUN;
          cnt_nxt   = '0;
          taps_nxt  = taps_eff;
          blk_nxt   = in_word.block_end;
          tail_nxt  = in_word.block_end ? (taps_eff - CNT_W'(1)) : '0;
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(TAP_COUNT)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (tail_r != '0) begin
            state_nxt = S_RUN;
            cnt_nxt   = '0;
            tail_nxt  = tail_r - CNT_W'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      taps_r  <= '0;
      tail_r  <= '0;
      blk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      taps_r  <= taps_nxt;
      tail_r  <= tail_nxt;
      blk_r   <= blk_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_word_r.filtered_value <= acc;
      out_word_r.last_of_block  <= blk_r && (tail_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Tap ring: cell 0 is the head, samples shift away from it and the ring
  // turns toward it.
  generate
    for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] x_prev;
      logic                          wr_en;

      if (k == 0) begin : g_head
        assign x_prev = head_in;
      end else begin : g_body
        assign x_prev = x_q[k-1];
      end

      assign wr_en = in_acc && is_load && (int'(in_word.coef_index) == k);

      firfc_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (cell_ctl),
        .coef_wr_en   (wr_en),
        .coef_wr_data (in_word.coef_value),
        .x_prev       (x_prev),
        .x_next       (x_q[(k + 1) % TAP_COUNT]),
        .c_next       (c_q[(k + 1) % TAP_COUNT]),
        .x_q          (x_q[k]),
        .c_q          (c_q[k])
      );
    end
  endgenerate

  // Single multiply-accumulate at the ring head.
  firfc_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .x_in  (x_q[0]),
    .c_in  (c_q[0]),
    .acc   (acc)
  );

endmodule

// ----- rtl/firfc_checker.sv -----
// Port-level checks for the full-convolution FIR block, bound to the top level.
module firfc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input firfc_pkg::in_word_t               in_word,
  input logic                              out_valid,
  input logic                              out_stall,
  input firfc_pkg::out_word_t              out_word
);
  import firfc_pkg::*;

  // A sample word keeps the block busy in the next cycle.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.command == CMD_FILTER) |=> in_stall)
    else $error("block ready right after a sample word");

  // A coefficient load does not make the block busy.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.command == CMD_LOAD) |=> !in_stall)
    else $error("block busy after a coefficient load");

  // No result can appear the cycle after a sample is taken.
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.command == CMD_FILTER) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fir_full_convolution firfc_checker u_firfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
